// ===== design/swm_pkg.sv =====
// Shared types and constants for the sliding window maximum block.
// No dependencies; used by swm_chain and sliding_window_maximum_top.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WLEN_W   = 7;

  typedef struct packed {
    logic shift;
    logic start;
  } step_t;

endpackage

`default_nettype wire

// ===== design/swm_cell.sv =====
// One cell of the running maximum chain: holds the maximum over a fixed span of ages.
// No package dependency; instantiated by swm_chain.
`timescale 1ns / 1ps
`default_nettype none

module swm_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire                           clk,
  input  wire                           en,
  input  wire                           link,
  input  wire  signed [SAMPLE_BITS-1:0] x,
  input  wire  signed [SAMPLE_BITS-1:0] prev_val,
  output logic signed [SAMPLE_BITS-1:0] val_r,
  output logic signed [SAMPLE_BITS-1:0] val_nxt
);

  always_comb begin
    if (link && (prev_val > x)) begin
      val_nxt = prev_val;
    end else begin
      val_nxt = x;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= val_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/swm_chain.sv =====
// Row of running maximum cells with their valid bits and the window tap select.
// Depends on swm_pkg and swm_cell.
`timescale 1ns / 1ps
`default_nettype none

module swm_chain #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16,
  localparam int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  swm_pkg::step_t                step,
  input  wire  signed [SAMPLE_BITS-1:0] x,
  input  wire         [IDX_W-1:0]       sel,
  output logic signed [SAMPLE_BITS-1:0] max_nxt
);

  logic signed [SAMPLE_BITS-1:0] val_r   [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] val_nxt [WINDOW_MAX];
  logic        [WINDOW_MAX-1:0]  vld_r;
  logic        [WINDOW_MAX-1:0]  vld_nxt;
  logic        [WINDOW_MAX-1:0]  link;

  genvar j;
  generate
    for (j = 0; j < WINDOW_MAX; j++) begin : g_cell
      if (j == 0) begin : g_head
        assign link[j]    = 1'b0;
        assign vld_nxt[j] = 1'b1;
        swm_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
          .clk      (clk),
          .en       (step.shift),
          .link     (link[j]),
          .x        (x),
          .prev_val (x),
          .val_r    (val_r[j]),
          .val_nxt  (val_nxt[j])
        );
      end else begin : g_body
        assign link[j]    = vld_r[j-1] & ~step.start;
        assign vld_nxt[j] = link[j];
        swm_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
          .clk      (clk),
          .en       (step.shift),
          .link     (link[j]),
          .x        (x),
          .prev_val (val_r[j-1]),
          .val_r    (val_r[j]),
          .val_nxt  (val_nxt[j])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (step.shift) begin
      vld_r <= vld_nxt;
    end
  end

  assign max_nxt = val_nxt[sel];

  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    step.shift |=> vld_r[0])
    else $error("head cell not valid after a shift");

  a_start_single: assert property (@(posedge clk) disable iff (!rst_n)
    (step.shift && step.start) |=> ($countones(vld_r) == 1))
    else $error("start did not leave exactly one valid cell");

  generate
    for (j = 1; j < WINDOW_MAX; j++) begin : g_chk
      a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        vld_r[j] |-> vld_r[j-1])
        else $error("valid cells do not form a prefix");
    end
  endgenerate

endmodule

`default_nettype wire

// ===== design/sliding_window_maximum_top.sv =====
// Top level of the sliding window maximum: stream ports, window register and output stage.
// Depends on swm_pkg and swm_chain.
//
//   channel | dir | tdata              | tuser
//   in_     | in  | [15:0] sample      | [0] start_req
//   out_    | out | [15:0] window_max  | -
//   cfg_    | in  | [6:0] window_length (write only)
//
// One request is taken per clock while no result waits; a result is registered and shows in the
// cycle after acceptance. The row of cells and the one-entry output register set this.
// Reset clears the valid bits, the sample count and the output valid flag; window length is 1.
// A result waiting on out_tready stalls the input only when it is not taken that cycle.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_maximum_top #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [swm_pkg::SAMPLE_W-1:0]        in_tdata,   // [15:0] sample
  input  wire  [0:0]                          in_tuser,   // [0] start_req
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [swm_pkg::SAMPLE_W-1:0]        out_tdata,  // [15:0] window_max
  input  wire                                 cfg_wr_en,
  input  wire  [swm_pkg::WLEN_W-1:0]          cfg_wr_data
);

  localparam int K_BITS = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CMP_W  = (K_BITS > swm_pkg::WLEN_W) ? K_BITS : swm_pkg::WLEN_W;

  logic [swm_pkg::WLEN_W-1:0]      wlen_r;
  logic [K_BITS-1:0]               seen_r;
  logic [K_BITS-1:0]               seen_nxt;
  logic [K_BITS-1:0]               seen_base;
  logic [K_BITS-1:0]               seen_cl;
  logic [CMP_W-1:0]                wl_ext;
  logic [CMP_W-1:0]                k_clamp;
  logic [K_BITS-1:0]               k_eff;
  logic [IDX_W-1:0]                sel;
  logic                            in_acc;
  logic                            emit;
  logic                            out_tvalid_r;
  logic                            out_tvalid_nxt;
  logic [swm_pkg::SAMPLE_W-1:0]    out_tdata_r;
  logic [SAMPLE_BITS+swm_pkg::SAMPLE_W-1:0] x_wide;
  logic [SAMPLE_BITS+swm_pkg::SAMPLE_W-1:0] max_wide;
  logic signed [SAMPLE_BITS-1:0]   x;
  logic signed [SAMPLE_BITS-1:0]   max_nxt;
  swm_pkg::step_t                  step;

  assign in_tready = !out_tvalid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign x_wide = {{SAMPLE_BITS{1'b0}}, in_tdata};
  assign x      = x_wide[SAMPLE_BITS-1:0];

  assign step.shift = in_acc;
  assign step.start = in_tuser[0];

  always_comb begin
    wl_ext = CMP_W'(wlen_r);
    if (wl_ext == '0) begin
      k_clamp = CMP_W'(1);
    end else if (wl_ext > CMP_W'(WINDOW_MAX)) begin
      k_clamp = CMP_W'(WINDOW_MAX);
    end else begin
      k_clamp = wl_ext;
    end
    k_eff = k_clamp[K_BITS-1:0];
    sel   = IDX_W'(k_eff - 1'b1);

    seen_base = in_tuser[0] ? '0 : seen_r;
    seen_cl   = (seen_base > k_eff) ? k_eff : seen_base;
    seen_nxt  = (seen_cl < k_eff) ? K_BITS'(seen_cl + 1'b1) : seen_cl;
    emit      = (seen_nxt >= k_eff);
  end

  swm_chain #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .x       (x),
    .sel     (sel),
    .max_nxt (max_nxt)
  );

  assign max_wide = {{swm_pkg::SAMPLE_W{1'b0}}, max_nxt};

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (in_acc) begin
      out_tvalid_nxt = emit;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r       <= swm_pkg::WLEN_W'(1);
      seen_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        wlen_r <= cfg_wr_data;
      end
      if (in_acc) begin
        seen_r <= seen_nxt;
      end
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_tdata_r <= max_wide[swm_pkg::SAMPLE_W-1:0];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_start_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[0]) |=> (seen_r == K_BITS'(1)))
    else $error("sample count not one after a start request");

  a_start_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[0]) |=> (out_tvalid_r == $past(k_eff == K_BITS'(1))))
    else $error("result after a start request disagrees with the window length");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(seen_r))
    else $error("sample count moved without a request");

endmodule

`default_nettype wire

// ===== bench/tb_sliding_window_maximum_top.sv =====
// Self-checking testbench for sliding_window_maximum_top: a running window maximum predictor
// built on a monotonic deque checks every result under gaps, stalls and window changes.
// Depends on swm_pkg and the sliding_window_maximum_top RTL.
`timescale 1ns / 1ps

module tb_sliding_window_maximum_top;

  localparam int DEPTH         = 64;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int EXP_DEPTH     = 4096;

  logic                         clk         = 1'b0;
  logic                         rst_n       = 1'b0;
  logic                         in_tvalid   = 1'b0;
  logic                         in_tready;
  logic [swm_pkg::SAMPLE_W-1:0] in_tdata    = '0;
  logic [0:0]                   in_tuser    = '0;
  logic                         out_tvalid;
  logic                         out_tready  = 1'b0;
  logic [swm_pkg::SAMPLE_W-1:0] out_tdata;
  logic                         cfg_wr_en   = 1'b0;
  logic [swm_pkg::WLEN_W-1:0]   cfg_wr_data = '0;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_off_left   = 0;
  int error_count     = 0;
  int cycle_count     = 0;
  int samples_sent    = 0;
  int starts_sent     = 0;
  int maxima_checked  = 0;
  int window_writes   = 0;

  logic [swm_pkg::WLEN_W-1:0]          window_reg = 7'd1;
  logic signed [swm_pkg::SAMPLE_W-1:0] dq_value [DEPTH];
  logic [swm_pkg::WLEN_W-1:0]          dq_arrival [DEPTH];
  int                                  dq_count = 0;
  logic [swm_pkg::WLEN_W-1:0]          next_arrival = '0;
  int                                  seen_in_seq = 0;
  logic signed [swm_pkg::SAMPLE_W-1:0] expected_max_mem [EXP_DEPTH];
  int                                  exp_wr = 0;
  int                                  exp_rd = 0;

  sliding_window_maximum_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int effective_window(input logic [swm_pkg::WLEN_W-1:0] w);
    if (w == 0) return 1;
    if (w > DEPTH) return DEPTH;
    return int'(w);
  endfunction

  task automatic track_sample(input logic signed [swm_pkg::SAMPLE_W-1:0] s, input bit start);
    int k;
    int drop;
    int i;
    logic [swm_pkg::WLEN_W-1:0] age;
    k = effective_window(window_reg);
    if (start) begin
      dq_count = 0;
      next_arrival = '0;
      seen_in_seq = 0;
    end
    drop = 0;
    while (drop < dq_count) begin
      age = next_arrival - dq_arrival[drop];
      if (age < k) break;
      drop++;
    end
    for (i = 0; i + drop < dq_count; i++) begin
      dq_value[i] = dq_value[i + drop];
      dq_arrival[i] = dq_arrival[i + drop];
    end
    dq_count -= drop;
    while (dq_count > 0 && dq_value[dq_count - 1] < s) dq_count--;
    if (dq_count < DEPTH) begin
      dq_value[dq_count] = s;
      dq_arrival[dq_count] = next_arrival;
      dq_count++;
    end
    next_arrival = next_arrival + 1'b1;
    if (seen_in_seq > k) seen_in_seq = k;
    if (seen_in_seq < k) seen_in_seq++;
    if (seen_in_seq >= k && dq_count > 0) begin
      expected_max_mem[exp_wr % EXP_DEPTH] = dq_value[0];
      exp_wr++;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic send_sample(input logic [swm_pkg::SAMPLE_W-1:0] s, input bit start);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = s;
    in_tuser[0] = start;
    do @(posedge clk); while (!in_tready);
    track_sample(s, start);
    samples_sent++;
    if (start) starts_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    in_tvalid = 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [swm_pkg::WLEN_W-1:0] w);
    drain();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = w;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    window_reg = w;
    window_writes++;
  endtask

  function automatic logic [swm_pkg::WLEN_W-1:0] pick_window();
    case ($urandom_range(9))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd2;
      3: return 7'd64;
      4: return 7'd65;
      5: return 7'd127;
      6: return 7'd63;
      default: return 7'($urandom_range(3, 20));
    endcase
  endfunction

  function automatic logic [swm_pkg::SAMPLE_W-1:0] make_sample(input int mode, input int j,
      input logic [swm_pkg::SAMPLE_W-1:0] base);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 6) - 3);
      2: return base - 16'(j * 3);
      3: return base + 16'(j * 3);
      default: begin
        case ($urandom_range(3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  task automatic test_default_window;
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
  endtask

  task automatic test_short_window;
    write_window(7'd3);
    send_sample(16'd5, 1'b1);
    send_sample(16'd5, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'd7, 1'b0);
    send_sample(16'd2, 1'b1);
    send_sample(16'd1, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd9, 1'b0);
  endtask

  task automatic test_shrink_and_grow;
    int i;
    write_window(7'd5);
    for (i = 0; i < 6; i++) send_sample(16'(10 - i), i == 0);
    write_window(7'd2);
    send_sample(16'd4, 1'b0);
    send_sample(16'd3, 1'b0);
    write_window(7'd4);
    send_sample(16'd1, 1'b0);
    send_sample(16'd2, 1'b0);
    send_sample(16'hFFF0, 1'b0);
  endtask

  task automatic test_zero_window;
    write_window(7'd0);
    send_sample(16'hFFFB, 1'b1);
    send_sample(16'd6, 1'b0);
  endtask

  task automatic test_random_phase(input int n_items, input int idle_pct, input int stall_pct);
    int count;
    int k;
    int len;
    int mode;
    int j;
    bit change_mid;
    logic [swm_pkg::SAMPLE_W-1:0] base;
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    count = 0;
    while (count < n_items) begin
      if ($urandom_range(3) == 0 || count == 0) write_window(pick_window());
      k = effective_window(window_reg);
      len = ($urandom_range(9) == 0) ? $urandom_range(1, k) : k + $urandom_range(0, 2 * k);
      mode = $urandom_range(4);
      base = 16'($urandom);
      change_mid = ($urandom_range(5) == 0);
      for (j = 0; j < len && count < n_items; j++) begin
        if (change_mid && j == len / 2) write_window(pick_window());
        send_sample(make_sample(mode, j, base), (j == 0) || ($urandom_range(49) == 0));
        count++;
      end
    end
    drain();
  endtask

  task automatic test_backpressure;
    int j;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    write_window(7'd4);
    hold_off_left = 300;
    for (j = 0; j < 120; j++) send_sample(16'($urandom), j == 0);
    drain();
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_tready = 1'b0;
        hold_off_left--;
      end else begin
        out_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_wr == exp_rd) begin
        report_mismatch($sformatf("window_max %0d with nothing expected", $signed(out_tdata)));
      end else begin
        if (out_tdata !== expected_max_mem[exp_rd % EXP_DEPTH])
          report_mismatch($sformatf("window_max expected %0d, got %0d",
                                    expected_max_mem[exp_rd % EXP_DEPTH], $signed(out_tdata)));
        exp_rd++;
        maxima_checked++;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results pending.", cycle_count,
             exp_wr - exp_rd);
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_window();
    test_short_window();
    test_shrink_and_grow();
    test_zero_window();
    drain();
    test_random_phase(380, 0, 0);
    test_random_phase(350, 73, 0);
    test_random_phase(350, 0, 73);
    test_random_phase(350, 20, 20);
    test_backpressure();

    if (exp_wr != exp_rd)
      report_mismatch($sformatf("%0d expected results never arrived", exp_wr - exp_rd));
    $display("Sent %0d samples in %0d sequences, checked %0d window maxima, %0d window writes.",
             samples_sent, starts_sent, maxima_checked, window_writes);
    $display("Covered extremes, equal samples, restarts, shrink and grow, gaps and a long hold.");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
